// File: rtl/sbn_pkg.sv
// Types and constants shared by the Stern-Brocot navigator and its channel interfaces.
// Depends on nothing.

package sbn_pkg;

    localparam int IN_BITS    = 32;
    localparam int DEPTH_BITS = 33;
    localparam int TERM_BITS  = 34;

    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_UP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UP_ROOT  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                mode;
        logic [IN_BITS-1:0]   in_num;
        logic [IN_BITS-1:0]   in_den;
        logic [IN_BITS-1:0]   in_steps;
    } t_cmd;

    typedef struct packed {
        t_status               status;
        logic [IN_BITS-1:0]    cur_num;
        logic [IN_BITS-1:0]    cur_den;
        logic [IN_BITS-1:0]    lo_num;
        logic [IN_BITS-1:0]    lo_den;
        logic [IN_BITS-1:0]    hi_num;
        logic [IN_BITS-1:0]    hi_den;
        logic [DEPTH_BITS-1:0] tree_depth;
    } t_rsp;

endpackage

// File: rtl/sbn_if.sv
// Valid/ready channel interfaces for command and response words.
// Depends on sbn_pkg.

interface sbn_cmd_if import sbn_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sbn_rsp_if import sbn_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/stern_brocot_navigator.sv
// Stern-Brocot tree navigator: sequencer, shift-add multiplier, restoring divider, term memory.
// Depends on sbn_pkg and the channel interfaces in sbn_if.
//
//   port      dir  word   content
//   i_cmd     in   t_cmd  mode, in_num, in_den, in_steps
//   o_rsp     out  t_rsp  status, fraction, bounds, depth
//
// One command at a time; i_cmd.ready is high only while the sequencer is idle.
// Move right/left: one shift-add multiply.
// Move up: one shift-add multiply per term walked back, plus a pop step per term popped.
// Set: one restoring division per Euclid quotient, then at most one shift-add multiply
// per quotient to rebuild the bounds.
// A finished word waits in the output register; a stalled o_rsp holds the sequencer
// before its next command. Synchronous reset returns the block to the root 1/1.

module stern_brocot_navigator import sbn_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_TERMS  = 48
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sbn_cmd_if.sink   i_cmd,
    sbn_rsp_if.source o_rsp
);

    localparam int VB  = VALUE_BITS;
    localparam int IW  = $clog2(MAX_TERMS);
    localparam int TCW = $clog2(MAX_TERMS + 1);
    localparam int CW  = $clog2(IN_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_EU_TEST, S_DIV, S_EU_NEXT, S_SB_READ, S_SB_K, S_DN_CHK,
        S_MUL, S_DN_APPLY, S_UP_LOOP, S_UP_APPLY, S_UP_POP, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    // committed node
    logic [VB-1:0]         r_fn, r_fd, r_ln, r_ld, r_hn, r_hd;
    logic [DEPTH_BITS-1:0] r_dep;
    logic [TCW-1:0]        r_tc;
    logic [TERM_BITS-1:0]  r_top;
    logic                  r_bank;

    // working copy
    logic [VB-1:0]         r_wfn, r_wfd, r_wln, r_wld, r_whn, r_whd;
    logic [DEPTH_BITS-1:0] r_wdep;
    logic [TCW-1:0]        r_wtc;
    logic [TERM_BITS-1:0]  r_wtop;

    t_mode                 r_mode;
    t_status               r_status;
    logic [IN_BITS-1:0]    r_k, r_x;
    logic                  r_right, r_app;
    logic [TCW-1:0]        r_n, r_i;

    // shared multiply / divide unit
    logic [VB-1:0]         r_mcn, r_mcd, r_accn, r_accd;
    logic                  r_ovf;
    logic [IN_BITS-1:0]    r_mplr;
    logic [CW-1:0]         r_cnt;
    logic [IN_BITS-1:0]    r_ea, r_eb, r_dq, r_rem;

    logic                  r_ovalid;
    t_rsp                  r_rsp;

    // term memory: two banks, the one not in use takes the terms of a set
    logic [TERM_BITS-1:0]  r_mem [2**(IW+1)];
    logic [TERM_BITS-1:0]  r_rd;
    logic                  mem_we, mem_re;
    logic [IW:0]           mem_wa, mem_ra;
    logic [TERM_BITS-1:0]  mem_wd;

    logic [VB+1:0]         mul_wn, mul_wd;
    logic [IN_BITS:0]      div_t, div_s;
    logic                  div_ge;
    logic [VB:0]           dn_sn, dn_sd;
    logic                  dn_bad, dn_deep, tc_full, sb_last;
    logic [TCW-1:0]        tc_m1, tc_m2;
    logic [TERM_BITS-1:0]  top_m1, up_top;
    logic [IN_BITS-1:0]    up_x;
    logic                  up_pop;

    always_comb begin
        mul_wn  = {1'b0, r_accn, 1'b0} + (VB+2)'(r_mplr[IN_BITS-1] ? r_mcn : '0);
        mul_wd  = {1'b0, r_accd, 1'b0} + (VB+2)'(r_mplr[IN_BITS-1] ? r_mcd : '0);
        div_t   = {r_rem, r_dq[IN_BITS-1]};
        div_ge  = div_t >= {1'b0, r_eb};
        div_s   = div_t - {1'b0, r_eb};
        dn_sn   = {1'b0, r_wfn} + {1'b0, r_accn};
        dn_sd   = {1'b0, r_wfd} + {1'b0, r_accd};
        dn_bad  = r_ovf | dn_sn[VB] | dn_sd[VB];
        dn_deep = DEPTH_BITS'(r_k) > ~r_wdep;
        tc_full = r_wtc >= TCW'(MAX_TERMS);
        sb_last = r_i == (r_n - 1'b1);
        tc_m1   = r_wtc - 1'b1;
        tc_m2   = r_wtc - TCW'(2);
        top_m1  = r_wtop - 1'b1;
        if (r_wtop == '0) begin
            up_x = '0;
        end else if (top_m1 > TERM_BITS'(r_k)) begin
            up_x = r_k;
        end else begin
            up_x = top_m1[IN_BITS-1:0];
        end
        up_top = r_wtop - TERM_BITS'(r_x);
        up_pop = (up_top == TERM_BITS'(1)) && (r_wtc > TCW'(1));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        case (r_state)
            S_EU_NEXT: begin
                mem_we = 1'b1;
                mem_wa = {~r_bank, r_n[IW-1:0]};
                mem_wd = TERM_BITS'(r_dq);
            end
            S_DN_APPLY: begin
                mem_we = !dn_bad && r_mode != MODE_SET && r_app;
                mem_wa = {r_bank, tc_m1[IW-1:0]};
                mem_wd = r_wtop - 1'b1;
            end
            S_SB_READ: begin
                mem_re = 1'b1;
                mem_ra = {~r_bank, r_i[IW-1:0]};
            end
            S_UP_APPLY: begin
                mem_re = up_pop;
                mem_ra = {r_bank, tc_m2[IW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_ra];
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fn     <= VB'(1);
            r_fd     <= VB'(1);
            r_ln     <= '0;
            r_ld     <= VB'(1);
            r_hn     <= VB'(1);
            r_hd     <= '0;
            r_dep    <= '0;
            r_tc     <= TCW'(1);
            r_top    <= TERM_BITS'(1);
            r_bank   <= 1'b0;
        end else begin
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_mode   <= i_cmd.data.mode;
                        r_k      <= i_cmd.data.in_steps;
                        r_right  <= i_cmd.data.mode == MODE_RIGHT;
                        r_app    <= (r_tc[0] == 1'b0) == (i_cmd.data.mode == MODE_RIGHT);
                        r_status <= ST_OK;
                        r_wfn <= r_fn;  r_wfd <= r_fd;
                        r_wln <= r_ln;  r_wld <= r_ld;
                        r_whn <= r_hn;  r_whd <= r_hd;
                        r_wdep <= r_dep;
                        r_wtc  <= r_tc;
                        r_wtop <= r_top;
                        unique case (i_cmd.data.mode)
                            MODE_SET: begin
                                r_ea <= i_cmd.data.in_num;
                                r_eb <= i_cmd.data.in_den;
                                r_n  <= '0;
                                if (i_cmd.data.in_num == '0 || i_cmd.data.in_den == '0) begin
                                    r_status <= ST_ZERO;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_state <= S_EU_TEST;
                                end
                            end
                            MODE_UP: begin
                                if (DEPTH_BITS'(i_cmd.data.in_steps) > r_dep) begin
                                    r_status <= ST_UP_ROOT;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_state <= S_UP_LOOP;
                                end
                            end
                            default: r_state <= S_DN_CHK;
                        endcase
                    end
                end
                S_EU_TEST: begin
                    if (r_eb == '0) begin
                        // quotients done: rebuild the node from the root
                        r_wtc <= r_n;
                        r_wfn <= VB'(1);  r_wfd <= VB'(1);
                        r_wln <= '0;      r_wld <= VB'(1);
                        r_whn <= VB'(1);  r_whd <= '0;
                        r_wdep <= '0;
                        r_i <= '0;
                        r_state <= S_SB_READ;
                    end else if (r_n >= TCW'(MAX_TERMS)) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_FIN;
                    end else begin
                        r_dq    <= r_ea;
                        r_rem   <= '0;
                        r_cnt   <= CW'(IN_BITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dq  <= {r_dq[IN_BITS-2:0], div_ge};
                    r_rem <= div_ge ? div_s[IN_BITS-1:0] : div_t[IN_BITS-1:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_EU_NEXT;
                end
                S_EU_NEXT: begin
                    r_wtop  <= TERM_BITS'(r_dq);
                    r_n     <= r_n + 1'b1;
                    r_ea    <= r_eb;
                    r_eb    <= r_rem;
                    r_state <= S_EU_TEST;
                end
                S_SB_READ: r_state <= S_SB_K;
                S_SB_K: begin
                    r_k     <= IN_BITS'(r_rd - TERM_BITS'(sb_last));
                    r_right <= !r_i[0];
                    r_state <= S_DN_CHK;
                end
                S_DN_CHK: begin
                    if (r_k == '0) begin
                        if (r_mode == MODE_SET && !sb_last) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_SB_READ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (dn_deep || (r_mode != MODE_SET && r_app && tc_full)) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_FIN;
                    end else begin
                        r_mcn   <= r_right ? r_whn : r_wln;
                        r_mcd   <= r_right ? r_whd : r_wld;
                        r_mplr  <= r_k;
                        r_accn  <= '0;
                        r_accd  <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= CW'(IN_BITS - 1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // MSB-first shift-add; any carry past VB bits marks overflow
                    r_accn <= mul_wn[VB-1:0];
                    r_accd <= mul_wd[VB-1:0];
                    r_ovf  <= r_ovf | (|mul_wn[VB+1:VB]) | (|mul_wd[VB+1:VB]);
                    r_mplr <= {r_mplr[IN_BITS-2:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= (r_mode == MODE_UP) ? S_UP_APPLY : S_DN_APPLY;
                end
                S_DN_APPLY: begin
                    if (dn_bad) begin
                        r_status <= ST_OVERFLOW;
                        r_state  <= S_FIN;
                    end else begin
                        r_wfn <= dn_sn[VB-1:0];
                        r_wfd <= dn_sd[VB-1:0];
                        if (r_right) begin
                            r_wln <= dn_sn[VB-1:0] - r_whn;
                            r_wld <= dn_sd[VB-1:0] - r_whd;
                        end else begin
                            r_whn <= dn_sn[VB-1:0] - r_wln;
                            r_whd <= dn_sd[VB-1:0] - r_wld;
                        end
                        r_wdep <= r_wdep + DEPTH_BITS'(r_k);
                        if (r_mode == MODE_SET) begin
                            if (sb_last) begin
                                r_state <= S_FIN;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_SB_READ;
                            end
                        end else begin
                            if (r_app) begin
                                r_wtop <= TERM_BITS'(r_k) + 1'b1;
                                r_wtc  <= r_wtc + 1'b1;
                            end else begin
                                r_wtop <= r_wtop + TERM_BITS'(r_k);
                            end
                            r_state <= S_FIN;
                        end
                    end
                end
                S_UP_LOOP: begin
                    if (r_k == '0 || up_x == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_x     <= up_x;
                        r_mcn   <= r_wtc[0] ? r_whn : r_wln;
                        r_mcd   <= r_wtc[0] ? r_whd : r_wld;
                        r_mplr  <= up_x;
                        r_accn  <= '0;
                        r_accd  <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= CW'(IN_BITS - 1);
                        r_state <= S_MUL;
                    end
                end
                S_UP_APPLY: begin
                    r_wfn <= r_wfn - r_accn;
                    r_wfd <= r_wfd - r_accd;
                    if (r_wtc[0]) begin
                        r_wln <= r_wln - r_accn;
                        r_wld <= r_wld - r_accd;
                    end else begin
                        r_whn <= r_whn - r_accn;
                        r_whd <= r_whd - r_accd;
                    end
                    r_wtop <= up_top;
                    r_wdep <= r_wdep - DEPTH_BITS'(r_x);
                    r_k    <= r_k - r_x;
                    r_state <= up_pop ? S_UP_POP : S_UP_LOOP;
                end
                S_UP_POP: begin
                    // drop the exhausted term and lengthen the one below
                    r_wtop  <= r_rd + 1'b1;
                    r_wtc   <= tc_m1;
                    r_state <= S_UP_LOOP;
                end
                S_FIN: begin
                    if (r_status == ST_OK) begin
                        r_fn <= r_wfn;  r_fd <= r_wfd;
                        r_ln <= r_wln;  r_ld <= r_wld;
                        r_hn <= r_whn;  r_hd <= r_whd;
                        r_dep <= r_wdep;
                        r_tc  <= r_wtc;
                        r_top <= r_wtop;
                        if (r_mode == MODE_SET) r_bank <= ~r_bank;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_rsp.status     <= r_status;
                        r_rsp.cur_num    <= IN_BITS'(r_fn);
                        r_rsp.cur_den    <= IN_BITS'(r_fd);
                        r_rsp.lo_num     <= IN_BITS'(r_ln);
                        r_rsp.lo_den     <= IN_BITS'(r_ld);
                        r_rsp.hi_num     <= IN_BITS'(r_hn);
                        r_rsp.hi_den     <= IN_BITS'(r_hd);
                        r_rsp.tree_depth <= r_dep;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_tc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tc != '0 && r_tc <= TCW'(MAX_TERMS))
        else $error("term count out of range");

    a_frac_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fn != '0 && r_fd != '0)
        else $error("current fraction has a zero part");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_state != S_IDLE)
        else $error("sequencer idle after accepting a command");

    a_root_status_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_status == ST_UP_ROOT |-> r_mode == MODE_UP)
        else $error("up-past-root status on a non-up command");

    a_fail_keeps_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_status != ST_OK |=> $stable(r_fn) && $stable(r_dep)
            && $stable(r_bank))
        else $error("failed command changed the node");
`endif

endmodule
